### rtl/cpu8_register_alu_execute_unit_macros.svh
// assertion macros shared by the execute unit rtl
// no dependencies; included by files that carry assertions
`ifndef CPU8_REGISTER_ALU_EXECUTE_UNIT_MACROS_SVH
`define CPU8_REGISTER_ALU_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPU8_ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cpu8 assertion failed");

// next-cycle implication, disabled during reset
`define CPU8_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cpu8 assertion failed");

`endif

### rtl/cpu8_pkg.sv
// types, command codes and flag positions for the 8-bit execute unit
// no dependencies
package cpu8_pkg;

  typedef enum logic [5:0] {
    CMD_LDA = 6'd0,  CMD_LDX = 6'd1,  CMD_LDY = 6'd2,  CMD_STA = 6'd3,
    CMD_STX = 6'd4,  CMD_STY = 6'd5,  CMD_AND = 6'd6,  CMD_ORA = 6'd7,
    CMD_EOR = 6'd8,  CMD_ADC = 6'd9,  CMD_SBC = 6'd10, CMD_CMP = 6'd11,
    CMD_CPX = 6'd12, CMD_CPY = 6'd13, CMD_BIT = 6'd14, CMD_ASL = 6'd15,
    CMD_LSR = 6'd16, CMD_ROL = 6'd17, CMD_ROR = 6'd18, CMD_INC = 6'd19,
    CMD_DEC = 6'd20, CMD_INX = 6'd21, CMD_INY = 6'd22, CMD_DEX = 6'd23,
    CMD_DEY = 6'd24, CMD_TAX = 6'd25, CMD_TAY = 6'd26, CMD_TXA = 6'd27,
    CMD_TYA = 6'd28, CMD_TSX = 6'd29, CMD_TXS = 6'd30, CMD_CLC = 6'd31,
    CMD_SEC = 6'd32, CMD_CLD = 6'd33, CMD_SED = 6'd34, CMD_CLI = 6'd35,
    CMD_SEI = 6'd36, CMD_CLV = 6'd37, CMD_PHA = 6'd38, CMD_PHP = 6'd39,
    CMD_PLA = 6'd40, CMD_PLP = 6'd41, CMD_BRK = 6'd42, CMD_BRANCH = 6'd43,
    CMD_NOP = 6'd44
  } cmd_t;

  // branch flag select, taken from the upper two condition bits
  typedef enum logic [1:0] {
    BSEL_N = 2'd0,
    BSEL_V = 2'd1,
    BSEL_C = 2'd2,
    BSEL_Z = 2'd3
  } bsel_t;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] BU_MASK    = 8'h30;
  localparam logic [8:0] STACK_PAGE = 9'h100;
  localparam logic [7:0] SP_RESET   = 8'hFF;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [5:0]  command;
    logic [7:0]  operand;
    logic        to_memory;
    logic [2:0]  branch_condition;
    logic [15:0] pc;
  } item_t;

  // per-item side outputs; register values travel separately as regs_t
  typedef struct packed {
    logic [7:0]  result;
    logic        write_enable;
    logic [8:0]  stack_address;
    logic        branch_taken;
    logic [15:0] next_pc;
    logic        page_crossed;
    logic        decimal_error;
  } side_t;

endpackage

### rtl/cpu8_alu.sv
// combinational execute logic: one decoded command against the register file
// depends on cpu8_pkg
module cpu8_alu
  import cpu8_pkg::*;
(
  input  item_t item,
  input  regs_t cur,
  output regs_t nxt,
  output side_t side
);

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q         = p;
    q[FLAG_Z] = (v == 8'h00);
    q[FLAG_N] = v[7];
    return q;
  endfunction

  logic [7:0]  m;
  logic [7:0]  addend;
  logic [8:0]  sum;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff;
  logic [7:0]  shv;
  logic [7:0]  shr;
  logic        shc;
  logic        bflag;
  logic        taken;
  logic [15:0] target;
  logic [7:0]  sp_inc;
  logic [7:0]  sp_dec;

  assign m      = item.operand;
  assign addend = (item.command == CMD_SBC) ? ~m : m;
  assign sum    = {1'b0, cur.a} + {1'b0, addend} + {8'h00, cur.p[FLAG_C]};
  assign sp_inc = cur.sp + 8'd1;
  assign sp_dec = cur.sp - 8'd1;

  always_comb begin
    case (item.command)
      CMD_CPX: cmp_reg = cur.x;
      CMD_CPY: cmp_reg = cur.y;
      default: cmp_reg = cur.a;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, m};

  assign shv = item.to_memory ? m : cur.a;
  always_comb begin
    case (item.command)
      CMD_ASL: begin
        shc = shv[7];
        shr = {shv[6:0], 1'b0};
      end
      CMD_LSR: begin
        shc = shv[0];
        shr = {1'b0, shv[7:1]};
      end
      CMD_ROL: begin
        shc = shv[7];
        shr = {shv[6:0], cur.p[FLAG_C]};
      end
      default: begin
        shc = shv[0];
        shr = {cur.p[FLAG_C], shv[7:1]};
      end
    endcase
  end

  always_comb begin
    case (bsel_t'(item.branch_condition[2:1]))
      BSEL_N:  bflag = cur.p[FLAG_N];
      BSEL_V:  bflag = cur.p[FLAG_V];
      BSEL_C:  bflag = cur.p[FLAG_C];
      BSEL_Z:  bflag = cur.p[FLAG_Z];
      default: bflag = cur.p[FLAG_Z];
    endcase
  end
  assign taken  = (bflag == item.branch_condition[0]);
  assign target = item.pc + {{8{m[7]}}, m};

  always_comb begin
    nxt  = cur;
    side = '0;
    side.stack_address = STACK_PAGE;
    side.next_pc       = item.pc;
    case (item.command)
      CMD_LDA: begin
        nxt.a = m;
        nxt.p = with_nz(cur.p, m);
      end
      CMD_LDX: begin
        nxt.x = m;
        nxt.p = with_nz(cur.p, m);
      end
      CMD_LDY: begin
        nxt.y = m;
        nxt.p = with_nz(cur.p, m);
      end
      CMD_STA: begin
        side.result       = cur.a;
        side.write_enable = 1'b1;
      end
      CMD_STX: begin
        side.result       = cur.x;
        side.write_enable = 1'b1;
      end
      CMD_STY: begin
        side.result       = cur.y;
        side.write_enable = 1'b1;
      end
      CMD_AND: begin
        nxt.a = cur.a & m;
        nxt.p = with_nz(cur.p, cur.a & m);
      end
      CMD_ORA: begin
        nxt.a = cur.a | m;
        nxt.p = with_nz(cur.p, cur.a | m);
      end
      CMD_EOR: begin
        nxt.a = cur.a ^ m;
        nxt.p = with_nz(cur.p, cur.a ^ m);
      end
      CMD_ADC, CMD_SBC: begin
        if (cur.p[FLAG_D]) begin
          side.decimal_error = 1'b1;
        end else begin
          nxt.a         = sum[7:0];
          nxt.p         = with_nz(cur.p, sum[7:0]);
          nxt.p[FLAG_C] = sum[8];
          // overflow: like-signed inputs give a result of the other sign
          nxt.p[FLAG_V] = ~(cur.a[7] ^ addend[7]) & (sum[7] ^ addend[7]);
        end
      end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        nxt.p[FLAG_N] = diff[7];
        nxt.p[FLAG_Z] = (cmp_reg == m);
        nxt.p[FLAG_C] = ~diff[8];
      end
      CMD_BIT: begin
        nxt.p[FLAG_Z] = ((cur.a & m) == 8'h00);
        nxt.p[FLAG_N] = m[7];
        nxt.p[FLAG_V] = m[6];
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        nxt.p         = with_nz(cur.p, shr);
        nxt.p[FLAG_C] = shc;
        if (item.to_memory) begin
          side.result       = shr;
          side.write_enable = 1'b1;
        end else begin
          nxt.a = shr;
        end
      end
      CMD_INC: begin
        side.result       = m + 8'd1;
        side.write_enable = 1'b1;
        nxt.p             = with_nz(cur.p, m + 8'd1);
      end
      CMD_DEC: begin
        side.result       = m - 8'd1;
        side.write_enable = 1'b1;
        nxt.p             = with_nz(cur.p, m - 8'd1);
      end
      CMD_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = with_nz(cur.p, cur.x + 8'd1);
      end
      CMD_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = with_nz(cur.p, cur.y + 8'd1);
      end
      CMD_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = with_nz(cur.p, cur.x - 8'd1);
      end
      CMD_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = with_nz(cur.p, cur.y - 8'd1);
      end
      CMD_TAX: begin
        nxt.x = cur.a;
        nxt.p = with_nz(cur.p, cur.a);
      end
      CMD_TAY: begin
        nxt.y = cur.a;
        nxt.p = with_nz(cur.p, cur.a);
      end
      CMD_TXA: begin
        nxt.a = cur.x;
        nxt.p = with_nz(cur.p, cur.x);
      end
      CMD_TYA: begin
        nxt.a = cur.y;
        nxt.p = with_nz(cur.p, cur.y);
      end
      CMD_TSX: begin
        nxt.x = cur.sp;
        nxt.p = with_nz(cur.p, cur.sp);
      end
      CMD_TXS: nxt.sp = cur.x;
      CMD_CLC: nxt.p[FLAG_C] = 1'b0;
      CMD_SEC: nxt.p[FLAG_C] = 1'b1;
      CMD_CLD: nxt.p[FLAG_D] = 1'b0;
      CMD_SED: nxt.p[FLAG_D] = 1'b1;
      CMD_CLI: nxt.p[FLAG_I] = 1'b0;
      CMD_SEI: nxt.p[FLAG_I] = 1'b1;
      CMD_CLV: nxt.p[FLAG_V] = 1'b0;
      CMD_PHA, CMD_PHP: begin
        side.result        = (item.command == CMD_PHA) ? cur.a : (cur.p | BU_MASK);
        side.write_enable  = 1'b1;
        side.stack_address = STACK_PAGE | {1'b0, cur.sp};
        nxt.sp             = sp_dec;
      end
      CMD_PLA: begin
        nxt.sp             = sp_inc;
        side.stack_address = STACK_PAGE | {1'b0, sp_inc};
        nxt.a              = m;
        nxt.p              = with_nz(cur.p, m);
      end
      CMD_PLP: begin
        nxt.sp             = sp_inc;
        side.stack_address = STACK_PAGE | {1'b0, sp_inc};
        nxt.p              = m & ~BU_MASK;
      end
      CMD_BRK: begin
        nxt.p[FLAG_B] = 1'b1;
        nxt.p[FLAG_I] = 1'b1;
      end
      CMD_BRANCH: begin
        side.branch_taken = taken;
        if (taken) begin
          side.next_pc      = target;
          side.page_crossed = (target[15:8] != item.pc[15:8]);
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/cpu8_register_alu_execute_unit.sv
// top level of the 8-bit execute unit: input register, register file, result register
// depends on cpu8_pkg, cpu8_alu and cpu8_register_alu_execute_unit_macros.svh
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | command operand to_memory branch_condition pc
//  out     | out_valid / out_ready| result write_enable stack_address registers flags
//                                   branch_taken next_pc page_crossed decimal_error
//
// one item per cycle sustained while the output is not stalled; each item is held
// in the input register, then executes as it moves into the result register,
// so registers update as the result is registered and the next item sees them at once
// a stalled output holds the result; the input register still takes one more item
// rst is synchronous: A, X, Y cleared, SP to 0xff, flags cleared, both stages empty
`include "cpu8_register_alu_execute_unit_macros.svh"

module cpu8_register_alu_execute_unit
  import cpu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  command,
  input  logic [7:0]  operand,
  input  logic        to_memory,
  input  logic [2:0]  branch_condition,
  input  logic [15:0] pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result,
  output logic        write_enable,
  output logic [8:0]  stack_address,
  output logic [7:0]  acc_value,
  output logic [7:0]  index_x_value,
  output logic [7:0]  index_y_value,
  output logic [7:0]  stack_pointer,
  output logic [7:0]  status,
  output logic        branch_taken,
  output logic [15:0] next_pc,
  output logic        page_crossed,
  output logic        decimal_error
);

  logic  hold_valid;
  item_t hold;
  regs_t regs;
  regs_t regs_next;
  side_t side_next;
  regs_t out_regs;
  side_t out_side;
  logic  exec;

  assign exec     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || exec;

  cpu8_alu u_alu (
    .item (hold),
    .cur  (regs),
    .nxt  (regs_next),
    .side (side_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      regs.a     <= 8'h00;
      regs.x     <= 8'h00;
      regs.y     <= 8'h00;
      regs.sp    <= SP_RESET;
      regs.p     <= 8'h00;
    end else begin
      hold_valid <= (in_valid && in_ready) || (hold_valid && !exec);
      out_valid  <= exec || (out_valid && !out_ready);
      if (exec) begin
        regs <= regs_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.command          <= command;
      hold.operand          <= operand;
      hold.to_memory        <= to_memory;
      hold.branch_condition <= branch_condition;
      hold.pc               <= pc;
    end
    if (exec) begin
      out_regs <= regs_next;
      out_side <= side_next;
    end
  end

  assign result        = out_side.result;
  assign write_enable  = out_side.write_enable;
  assign stack_address = out_side.stack_address;
  assign branch_taken  = out_side.branch_taken;
  assign next_pc       = out_side.next_pc;
  assign page_crossed  = out_side.page_crossed;
  assign decimal_error = out_side.decimal_error;
  assign acc_value     = out_regs.a;
  assign index_x_value = out_regs.x;
  assign index_y_value = out_regs.y;
  assign stack_pointer = out_regs.sp;
  assign status        = out_regs.p;

  // an executed item always lands in the result register
  `CPU8_ASSERT_NEXT(a_exec_fills_out, clk, rst, exec, out_valid)
  // the published registers match the live register file after each transfer
  `CPU8_ASSERT_NEXT(a_out_tracks_regs, clk, rst, exec, out_regs == regs)
  // a decimal-mode error writes nothing and never branches
  `CPU8_ASSERT_IMPLIES(a_derr_quiet, clk, rst, out_valid && decimal_error,
                       !write_enable && !branch_taken)
  // page crossing only comes from a taken branch
  `CPU8_ASSERT_IMPLIES(a_cross_taken, clk, rst, out_valid && page_crossed, branch_taken)

endmodule

### sim/tb_cpu8_register_alu_execute_unit.sv
// self-checking testbench for the 8-bit register and alu execute unit
// keeps its own copy of A, X, Y, SP and P to predict every result; needs cpu8_pkg and the rtl
module tb_cpu8_register_alu_execute_unit;
  import cpu8_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned BURST_ITEMS  = 30;
  localparam logic        TO_ACC       = 1'b0;
  localparam logic        TO_MEM       = 1'b1;
  localparam logic [5:0]  CMD_UNUSED_FIRST = 6'd45;
  localparam logic [5:0]  CMD_UNUSED_LAST  = 6'd63;

  typedef enum logic [2:0] {
    COND_BPL = 3'd0, COND_BMI = 3'd1, COND_BVC = 3'd2, COND_BVS = 3'd3,
    COND_BCC = 3'd4, COND_BCS = 3'd5, COND_BNE = 3'd6, COND_BEQ = 3'd7
  } branch_cond_t;

  typedef struct packed {
    side_t side;
    regs_t regs;
  } exec_outcome_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  command;
  logic [7:0]  operand;
  logic        to_memory;
  logic [2:0]  branch_condition;
  logic [15:0] pc;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  result;
  logic        write_enable;
  logic [8:0]  stack_address;
  logic [7:0]  acc_value;
  logic [7:0]  index_x_value;
  logic [7:0]  index_y_value;
  logic [7:0]  stack_pointer;
  logic [7:0]  status;
  logic        branch_taken;
  logic [15:0] next_pc;
  logic        page_crossed;
  logic        decimal_error;

  exec_outcome_t pending_outcomes[$];
  regs_t         arch_state;
  int unsigned   error_count;
  bit            tx_gaps_on;
  bit            rx_stalls_on;
  int unsigned   rx_hold_request;

  cpu8_register_alu_execute_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle stretch: mostly short, now and then long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    else if (r < 92) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void update_nz(input logic [7:0] v);
    arch_state.p[FLAG_Z] = (v == 8'h00);
    arch_state.p[FLAG_N] = v[7];
  endfunction

  function automatic void add_to_acc(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, arch_state.a} + {1'b0, m} + {8'h00, arch_state.p[FLAG_C]};
    // overflow when both inputs share a sign and the sum does not
    arch_state.p[FLAG_V] = ~(arch_state.a[7] ^ m[7]) & (sum[7] ^ m[7]);
    arch_state.p[FLAG_C] = sum[8];
    arch_state.a = sum[7:0];
    update_nz(sum[7:0]);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    arch_state.p[FLAG_N] = diff[7];
    arch_state.p[FLAG_Z] = (r == m);
    arch_state.p[FLAG_C] = (r >= m);
  endfunction

  function automatic logic [7:0] shift_rotate(input logic [5:0] cmd, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = arch_state.p[FLAG_C];
    case (cmd)
      CMD_ASL: begin
        arch_state.p[FLAG_C] = v[7];
        r = {v[6:0], 1'b0};
      end
      CMD_LSR: begin
        arch_state.p[FLAG_C] = v[0];
        r = {1'b0, v[7:1]};
      end
      CMD_ROL: begin
        arch_state.p[FLAG_C] = v[7];
        r = {v[6:0], cin};
      end
      default: begin
        arch_state.p[FLAG_C] = v[0];
        r = {cin, v[7:1]};
      end
    endcase
    update_nz(r);
    return r;
  endfunction

  // advances the architectural state by one command and returns what the unit should report
  function automatic exec_outcome_t predict_step(input logic [5:0] cmd, input logic [7:0] m,
                                                 input logic tgt, input logic [2:0] cond,
                                                 input logic [15:0] addr);
    exec_outcome_t o;
    logic          flag_sel;
    o = '0;
    o.side.stack_address = STACK_PAGE;
    o.side.next_pc = addr;
    case (cmd)
      CMD_LDA: begin arch_state.a = m; update_nz(m); end
      CMD_LDX: begin arch_state.x = m; update_nz(m); end
      CMD_LDY: begin arch_state.y = m; update_nz(m); end
      CMD_STA: begin o.side.result = arch_state.a; o.side.write_enable = 1'b1; end
      CMD_STX: begin o.side.result = arch_state.x; o.side.write_enable = 1'b1; end
      CMD_STY: begin o.side.result = arch_state.y; o.side.write_enable = 1'b1; end
      CMD_AND: begin arch_state.a = arch_state.a & m; update_nz(arch_state.a); end
      CMD_ORA: begin arch_state.a = arch_state.a | m; update_nz(arch_state.a); end
      CMD_EOR: begin arch_state.a = arch_state.a ^ m; update_nz(arch_state.a); end
      CMD_ADC, CMD_SBC: begin
        if (arch_state.p[FLAG_D]) o.side.decimal_error = 1'b1;
        else add_to_acc((cmd == CMD_ADC) ? m : ~m);
      end
      CMD_CMP: compare_reg(arch_state.a, m);
      CMD_CPX: compare_reg(arch_state.x, m);
      CMD_CPY: compare_reg(arch_state.y, m);
      CMD_BIT: begin
        arch_state.p[FLAG_Z] = ((arch_state.a & m) == 8'h00);
        arch_state.p[FLAG_N] = m[7];
        arch_state.p[FLAG_V] = m[6];
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        if (tgt == TO_MEM) begin
          o.side.result = shift_rotate(cmd, m);
          o.side.write_enable = 1'b1;
        end else begin
          arch_state.a = shift_rotate(cmd, arch_state.a);
        end
      end
      CMD_INC, CMD_DEC: begin
        o.side.result = (cmd == CMD_INC) ? m + 8'd1 : m - 8'd1;
        o.side.write_enable = 1'b1;
        update_nz(o.side.result);
      end
      CMD_INX: begin arch_state.x = arch_state.x + 8'd1; update_nz(arch_state.x); end
      CMD_INY: begin arch_state.y = arch_state.y + 8'd1; update_nz(arch_state.y); end
      CMD_DEX: begin arch_state.x = arch_state.x - 8'd1; update_nz(arch_state.x); end
      CMD_DEY: begin arch_state.y = arch_state.y - 8'd1; update_nz(arch_state.y); end
      CMD_TAX: begin arch_state.x = arch_state.a; update_nz(arch_state.x); end
      CMD_TAY: begin arch_state.y = arch_state.a; update_nz(arch_state.y); end
      CMD_TXA: begin arch_state.a = arch_state.x; update_nz(arch_state.a); end
      CMD_TYA: begin arch_state.a = arch_state.y; update_nz(arch_state.a); end
      CMD_TSX: begin arch_state.x = arch_state.sp; update_nz(arch_state.x); end
      CMD_TXS: arch_state.sp = arch_state.x;
      CMD_CLC: arch_state.p[FLAG_C] = 1'b0;
      CMD_SEC: arch_state.p[FLAG_C] = 1'b1;
      CMD_CLD: arch_state.p[FLAG_D] = 1'b0;
      CMD_SED: arch_state.p[FLAG_D] = 1'b1;
      CMD_CLI: arch_state.p[FLAG_I] = 1'b0;
      CMD_SEI: arch_state.p[FLAG_I] = 1'b1;
      CMD_CLV: arch_state.p[FLAG_V] = 1'b0;
      CMD_PHA, CMD_PHP: begin
        // pushed status always carries B and U
        o.side.result = (cmd == CMD_PHA) ? arch_state.a : (arch_state.p | BU_MASK);
        o.side.write_enable = 1'b1;
        o.side.stack_address = STACK_PAGE | {1'b0, arch_state.sp};
        arch_state.sp = arch_state.sp - 8'd1;
      end
      CMD_PLA, CMD_PLP: begin
        arch_state.sp = arch_state.sp + 8'd1;
        o.side.stack_address = STACK_PAGE | {1'b0, arch_state.sp};
        if (cmd == CMD_PLA) begin
          arch_state.a = m;
          update_nz(m);
        end else begin
          arch_state.p = m & ~BU_MASK;
        end
      end
      CMD_BRK: begin
        arch_state.p[FLAG_B] = 1'b1;
        arch_state.p[FLAG_I] = 1'b1;
      end
      CMD_BRANCH: begin
        case (bsel_t'(cond[2:1]))
          BSEL_N:  flag_sel = arch_state.p[FLAG_N];
          BSEL_V:  flag_sel = arch_state.p[FLAG_V];
          BSEL_C:  flag_sel = arch_state.p[FLAG_C];
          default: flag_sel = arch_state.p[FLAG_Z];
        endcase
        o.side.branch_taken = (flag_sel == cond[0]);
        if (o.side.branch_taken) begin
          o.side.next_pc = addr + {{8{m[7]}}, m};
          o.side.page_crossed = (o.side.next_pc[15:8] != addr[15:8]);
        end
      end
      default: ;
    endcase
    o.regs = arch_state;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endfunction

  // offers one item and records its prediction once the transfer happens
  task automatic send_op(input logic [5:0] cmd, input logic [7:0] opnd, input logic tgt,
                         input logic [2:0] cond, input logic [15:0] addr);
    int unsigned gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 2) == 0) gap = idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    command          <= cmd;
    operand          <= opnd;
    to_memory        <= tgt;
    branch_condition <= cond;
    pc               <= addr;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(predict_step(cmd, opnd, tgt, cond, addr));
  endtask

  task automatic send_random_op(input logic [5:0] cmd);
    send_op(cmd, 8'($urandom), 1'($urandom), 3'($urandom), 16'($urandom));
  endtask

  function automatic logic [5:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 6'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    else if (r < 12) return CMD_BRANCH;
    else if (r < 20) return ($urandom_range(0, 1) != 0) ? CMD_ADC : CMD_SBC;
    else return 6'($urandom_range(CMD_LDA, CMD_NOP));
  endfunction

  task automatic test_directed_cases();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // reset values seen through a nop with every input field at its top
    send_op(CMD_NOP, 8'hFF, TO_MEM, COND_BEQ, 16'hFFFF);
    // signed overflow, then carry out with a zero sum
    send_op(CMD_LDA, 8'h7F, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_ADC, 8'h01, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_SEC, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_LDA, 8'hFF, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_ADC, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    // subtraction through the complemented operand
    send_op(CMD_SEC, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_LDA, 8'h80, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_SBC, 8'h01, TO_ACC, COND_BPL, 16'h0000);
    // decimal mode refuses both adc and sbc
    send_op(CMD_SED, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_ADC, 8'h55, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_SBC, 8'h12, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_CLD, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    // pushed status gains B and U, pulled status loses them
    send_op(CMD_PHP, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_PLP, 8'hFF, TO_ACC, COND_BPL, 16'h0000);
    // largest forward and backward offsets, both wrapping the address space
    send_op(CMD_BRANCH, 8'h7F, TO_ACC, COND_BMI, 16'hFFF0);
    send_op(CMD_BRANCH, 8'h80, TO_ACC, COND_BVS, 16'h0000);
    send_op(CMD_BRK, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    // stack pointer wraps both ways around zero
    send_op(CMD_LDX, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_TXS, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_PHA, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    send_op(CMD_PLA, 8'h00, TO_ACC, COND_BPL, 16'h0000);
    // codes past the table behave as nop
    send_op(CMD_UNUSED_FIRST, 8'hA5, TO_MEM, COND_BCS, 16'h1234);
    send_op(CMD_UNUSED_LAST, 8'h5A, TO_ACC, COND_BCC, 16'h4321);
  endtask

  task automatic test_command_sweep();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    for (int c = 0; c < 64; c++) send_random_op(6'(c));
  endtask

  // long hold-off on the result side while items keep coming
  task automatic test_output_backpressure();
    tx_gaps_on      = 1'b0;
    rx_stalls_on    = 1'b0;
    rx_hold_request = HOLD_CYCLES;
    for (int i = 0; i < BURST_ITEMS; i++) send_random_op(pick_command());
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_gaps_on   = 1'($urandom_range(0, 1));
        rx_stalls_on = 1'($urandom_range(0, 1));
      end
      send_random_op(pick_command());
    end
  endtask

  // result side: random stalls plus the requested hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        stall_left      = rx_hold_request;
        rx_hold_request = 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
    end
  end

  always @(posedge clk) begin
    exec_outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no outstanding command");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("result", 16'(want.side.result), 16'(result));
        check_field("write_enable", 16'(want.side.write_enable), 16'(write_enable));
        check_field("stack_address", 16'(want.side.stack_address), 16'(stack_address));
        check_field("acc_value", 16'(want.regs.a), 16'(acc_value));
        check_field("index_x_value", 16'(want.regs.x), 16'(index_x_value));
        check_field("index_y_value", 16'(want.regs.y), 16'(index_y_value));
        check_field("stack_pointer", 16'(want.regs.sp), 16'(stack_pointer));
        check_field("status", 16'(want.regs.p), 16'(status));
        check_field("branch_taken", 16'(want.side.branch_taken), 16'(branch_taken));
        check_field("next_pc", want.side.next_pc, next_pc);
        check_field("page_crossed", 16'(want.side.page_crossed), 16'(page_crossed));
        check_field("decimal_error", 16'(want.side.decimal_error), 16'(decimal_error));
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    command          = CMD_NOP;
    operand          = 8'h00;
    to_memory        = TO_ACC;
    branch_condition = COND_BPL;
    pc               = 16'h0000;
    tx_gaps_on       = 1'b0;
    rx_stalls_on     = 1'b0;
    rx_hold_request  = 0;
    error_count      = 0;
    arch_state.a     = 8'h00;
    arch_state.x     = 8'h00;
    arch_state.y     = 8'h00;
    arch_state.sp    = SP_RESET;
    arch_state.p     = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_command_sweep();
    test_output_backpressure();
    test_random_mix(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
